### hw/rtl/rpsc_pkg.sv
`default_nettype none
package rpsc_pkg;

  localparam int PosW    = 24;
  localparam int CosW    = 18;
  localparam int EnergyW = 24;
  localparam int OutW    = 25;
  localparam int ProdW   = PosW + CosW;
  localparam int NumW    = ProdW + 1;
  localparam int MagW    = ProdW;
  localparam int SqW     = 2 * PosW;
  localparam int RootW   = PosW;
  localparam int QuotW   = 19;

  localparam logic [QuotW-1:0] CosOne = QuotW'(65536);
  localparam logic [1:0] ChargePositron = 2'b01;
  localparam logic [1:0] ChargePhoton   = 2'b00;

  // fields that ride alongside the arithmetic
  typedef struct packed {
    logic signed [OutW-1:0] energy;
    logic [CosW-1:0]        u;
    logic [CosW-1:0]        v;
    logic                   charged;
  } side_t;

endpackage
`default_nettype wire

### hw/rtl/reduced_phase_space_convert_unit.sv
`default_nettype none
// Reduced phase-space converter. Each input transaction carries one particle
// (x, y, u, v, kinetic energy, charge) and yields exactly one output transaction
// (signed energy, signed radius, radial cosine, azimuthal cosine). The radius
// is the truncated square root of x*x+y*y, negated for charged particles; the
// energy is negated for positrons; the cosines are (u*x+v*y)/r and (v*x-u*y)/r
// with truncation toward zero, saturated to +-1.0, and u, v pass through when
// the radius is zero. The datapath is a 48-stage pipeline: the input register,
// one stage of squares and products, one of sums, 24 square-root stages (one
// root bit each), one sign stage, 19 divider stages (one quotient bit each, two
// dividers side by side) and the output register. A transaction is taken
// every clock cycle unless the output is stalled. When the output is stalled
// the whole pipeline holds, so s_tready follows the output-side handshake;
// s_tready is low during reset.
module reduced_phase_space_convert_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // pos_x[23:0], pos_y[47:24], dir_u[65:48], dir_v[83:66],
  // kin_energy[107:84], particle_charge[109:108], zero pad
  input  wire logic [111:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_energy[24:0], signed_radius[49:25], radial_cosine[67:50],
  // azimuth_cosine[85:68], zero pad
  output logic      [87:0]  m_tdata
);

  localparam int PosW  = rpsc_pkg::PosW;
  localparam int CosW  = rpsc_pkg::CosW;
  localparam int OutW  = rpsc_pkg::OutW;
  localparam int ProdW = rpsc_pkg::ProdW;
  localparam int NumW  = rpsc_pkg::NumW;
  localparam int MagW  = rpsc_pkg::MagW;
  localparam int SqW   = rpsc_pkg::SqW;
  localparam int RootW = rpsc_pkg::RootW;
  localparam int QuotW = rpsc_pkg::QuotW;
  localparam int SideW = $bits(rpsc_pkg::side_t);
  localparam int Latency = 3 + RootW + 1 + QuotW + 1;

  // global advance: the pipeline moves whenever the output slot frees
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  logic [Latency-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Latency-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[Latency-1];

  // stage a: input capture and sideband
  logic signed [PosW-1:0] xa, ya;
  logic signed [CosW-1:0] ua, va;
  rpsc_pkg::side_t        side_a;
  logic [1:0]             chg_in;
  logic [OutW-1:0]        e_ext;

  assign chg_in = s_tdata[109:108];
  assign e_ext  = OutW'(s_tdata[107:84]);

  always_ff @(posedge clk) begin
    if (en) begin
      xa <= s_tdata[23:0];
      ya <= s_tdata[47:24];
      ua <= s_tdata[65:48];
      va <= s_tdata[83:66];
      side_a.energy  <= (chg_in == rpsc_pkg::ChargePositron) ? -e_ext : e_ext;
      side_a.u       <= s_tdata[65:48];
      side_a.v       <= s_tdata[83:66];
      side_a.charged <= chg_in != rpsc_pkg::ChargePhoton;
    end
  end

  // stage b: squares and cross products
  logic signed [SqW-1:0]   sqx, sqy;
  logic signed [ProdW-1:0] ux, vy, vx, uy;
  rpsc_pkg::side_t         side_b;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx    <= xa * xa;
      sqy    <= ya * ya;
      ux     <= ua * xa;
      vy     <= va * ya;
      vx     <= va * xa;
      uy     <= ua * ya;
      side_b <= side_a;
    end
  end

  // stage c: sum of squares and the two numerators
  logic [SqW-1:0]         sq;
  logic signed [NumW-1:0] nr_c, na_c;
  rpsc_pkg::side_t        side_c;

  always_ff @(posedge clk) begin
    if (en) begin
      sq     <= SqW'(sqx) + SqW'(sqy);
      nr_c   <= NumW'(ux) + NumW'(vy);
      na_c   <= NumW'(vx) - NumW'(uy);
      side_c <= side_b;
    end
  end

  // square root, numerators and sideband delayed to match
  logic [RootW-1:0]       root_r;
  logic [2*NumW+SideW-1:0] c_bus, c_dly;

  rpsc_isqrt #(.RootW(RootW)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sq),
    .root (root_r)
  );

  assign c_bus = {nr_c, na_c, side_c};

  rpsc_delay #(.Width(2*NumW+SideW), .Depth(RootW)) u_dly_sqrt (
    .clk  (clk),
    .en   (en),
    .din  (c_bus),
    .dout (c_dly)
  );

  logic signed [NumW-1:0] nr_r, na_r;
  rpsc_pkg::side_t        side_r;
  assign nr_r   = c_dly[2*NumW+SideW-1:NumW+SideW];
  assign na_r   = c_dly[NumW+SideW-1:SideW];
  assign side_r = c_dly[SideW-1:0];

  // stage d: magnitudes and quotient signs (negative radius flips the sign)
  logic [MagW-1:0]  nr_mag, na_mag;
  logic [RootW-1:0] root_d;
  logic             neg_r_d, neg_a_d;
  rpsc_pkg::side_t  side_d;
  logic [NumW-1:0]  nr_abs, na_abs;

  assign nr_abs = nr_r[NumW-1] ? NumW'(-nr_r) : NumW'(nr_r);
  assign na_abs = na_r[NumW-1] ? NumW'(-na_r) : NumW'(na_r);

  always_ff @(posedge clk) begin
    if (en) begin
      nr_mag  <= nr_abs[MagW-1:0];
      na_mag  <= na_abs[MagW-1:0];
      root_d  <= root_r;
      neg_r_d <= nr_r[NumW-1] ^ side_r.charged;
      neg_a_d <= na_r[NumW-1] ^ side_r.charged;
      side_d  <= side_r;
    end
  end

  // dividers, with radius, signs and sideband delayed alongside
  logic [QuotW-1:0] qr, qa;

  rpsc_div #(.NumW(MagW), .DenW(RootW), .QuotW(QuotW)) u_div_rad (
    .clk  (clk),
    .en   (en),
    .num  (nr_mag),
    .den  (root_d),
    .quot (qr)
  );

  rpsc_div #(.NumW(MagW), .DenW(RootW), .QuotW(QuotW)) u_div_azi (
    .clk  (clk),
    .en   (en),
    .num  (na_mag),
    .den  (root_d),
    .quot (qa)
  );

  logic [RootW+2+SideW-1:0] d_bus, d_dly;
  assign d_bus = {root_d, neg_r_d, neg_a_d, side_d};

  rpsc_delay #(.Width(RootW+2+SideW), .Depth(QuotW)) u_dly_div (
    .clk  (clk),
    .en   (en),
    .din  (d_bus),
    .dout (d_dly)
  );

  logic [RootW-1:0] root_e;
  logic             neg_r_e, neg_a_e;
  rpsc_pkg::side_t  side_e;
  assign root_e  = d_dly[RootW+2+SideW-1:2+SideW];
  assign neg_r_e = d_dly[SideW+1];
  assign neg_a_e = d_dly[SideW];
  assign side_e  = d_dly[SideW-1:0];

  // stage e: saturation, sign, zero-radius bypass
  logic [QuotW-1:0] qr_sat, qa_sat;
  logic [CosW-1:0]  ur_val, va_val;
  logic [OutW-1:0]  rad_mag;

  assign qr_sat  = (qr > rpsc_pkg::CosOne) ? rpsc_pkg::CosOne : qr;
  assign qa_sat  = (qa > rpsc_pkg::CosOne) ? rpsc_pkg::CosOne : qa;
  assign ur_val  = neg_r_e ? CosW'(-qr_sat) : CosW'(qr_sat);
  assign va_val  = neg_a_e ? CosW'(-qa_sat) : CosW'(qa_sat);
  assign rad_mag = OutW'(root_e);

  logic [OutW-1:0] energy_o, radius_o;
  logic [CosW-1:0] radial_o, azimuth_o;

  always_ff @(posedge clk) begin
    if (en) begin
      energy_o <= side_e.energy;
      radius_o <= side_e.charged ? -rad_mag : rad_mag;
      if (root_e == '0) begin
        radial_o  <= side_e.u;
        azimuth_o <= side_e.v;
      end else begin
        radial_o  <= ur_val;
        azimuth_o <= va_val;
      end
    end
  end

  assign m_tdata = {2'b00, azimuth_o, radial_o, radius_o, energy_o};

endmodule
`default_nettype wire

### hw/rtl/rpsc_delay.sv
`default_nettype none
module rpsc_delay #(
  parameter int Width = 8,
  parameter int Depth = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [Width-1:0] din,
  output logic      [Width-1:0] dout
);

  logic [Width-1:0] taps [Depth];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < Depth; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[Depth-1];

endmodule
`default_nettype wire

### hw/rtl/rpsc_isqrt.sv
`default_nettype none
// one root bit per stage, digit-by-digit square root
module rpsc_isqrt #(
  parameter int RootW = 24
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [2*RootW-1:0] rad,
  output logic      [RootW-1:0]   root
);

  localparam int RadW = 2 * RootW;
  localparam int RemW = RootW + 3;

  logic [RadW-1:0]  rad_q  [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RemW-1:0]  cur;
    logic [RemW-1:0]  trial;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign cur   = {rem_in[RemW-3:0], rad_in[RadW-1:RadW-2]};
    assign trial = RemW'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i] <= {rad_in[RadW-3:0], 2'b00};
        if (cur >= trial) begin
          rem_q[i]  <= cur - trial;
          root_q[i] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          rem_q[i]  <= cur;
          root_q[i] <= {root_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[RootW-1];

endmodule
`default_nettype wire

### hw/rtl/rpsc_div.sv
`default_nettype none
// restoring divider, one quotient bit per stage, msb first
module rpsc_div #(
  parameter int NumW  = 42,
  parameter int DenW  = 24,
  parameter int QuotW = 19
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NumW-1:0]  num,
  input  wire logic [DenW-1:0]  den,
  output logic      [QuotW-1:0] quot
);

  localparam int RemW = NumW + 1;

  logic [RemW-1:0]  rem_q  [QuotW];
  logic [DenW-1:0]  den_q  [QuotW];
  logic [QuotW-1:0] quot_q [QuotW];

  for (genvar j = 0; j < QuotW; j++) begin : g_stage
    logic [RemW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic [QuotW-1:0] quot_in;
    logic [RemW-1:0]  dsh;

    if (j == 0) begin : g_first
      assign rem_in  = RemW'(num);
      assign den_in  = den;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign den_in  = den_q[j-1];
      assign quot_in = quot_q[j-1];
    end

    assign dsh = RemW'(den_in) << (QuotW - 1 - j);

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[j] <= den_in;
        if (rem_in >= dsh) begin
          rem_q[j]  <= rem_in - dsh;
          quot_q[j] <= {quot_in[QuotW-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_in;
          quot_q[j] <= {quot_in[QuotW-2:0], 1'b0};
        end
      end
    end
  end

  assign quot = quot_q[QuotW-1];

endmodule
`default_nettype wire
